// ===== rtl/core/psoc_pkg.sv =====
package psoc_pkg;

  // Field and register widths
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned CFG_W     = 23;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned CFG_IDX_W = 2;
  // Room for a coordinate difference plus one box fold
  localparam int unsigned FOLD_W    = COORD_W + 3;

  localparam int unsigned MAX_SPHERES_DEF = 1024;

  // Register reset values
  localparam logic [CFG_W-1:0]   BOX_RST     = 23'd65536;
  localparam logic [CFG_W-1:0]   CONTACT_RST = 23'd4096;
  localparam logic [COUNT_W-1:0] COUNT_RST   = '0;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BOX     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTACT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 2'd2;

  // Request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [FOLD_W-1:0]  fold_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } pos_t;

  // One pair beat into the distance pipe
  typedef struct packed {
    logic valid;
    logic skip;
  } pair_req_t;

  // Pipe status back to the sequencer
  typedef struct packed {
    logic busy;
    logic hit;
  } pair_sts_t;

  // Fold once into the box: above half the box subtract it, below minus half add it.
  // Half-box bounds are tested as 2*c against the box to stay exact.
  function automatic fold_t fold_once(fold_t c, logic [CFG_W-1:0] box);
    logic signed [FOLD_W+1:0] two_c;
    logic signed [FOLD_W+1:0] box_w;
    fold_t                    box_f;
    fold_t                    res;
    two_c = {c[FOLD_W-1], c, 1'b0};
    box_w = $signed({{(FOLD_W+2-CFG_W){1'b0}}, box});
    box_f = $signed({{(FOLD_W-CFG_W){1'b0}}, box});
    if (two_c > box_w) begin
      res = c - box_f;
    end else if (two_c < -box_w) begin
      res = c + box_f;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/psoc_pair_pipe.sv =====
module psoc_pair_pipe
  import psoc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] box_i,
  input  logic [CFG_W-1:0] contact_i,
  input  pair_req_t        req_i,
  input  pos_t             entry_i,
  input  pos_t             query_i,
  output pair_sts_t        sts_o
);

  localparam int unsigned SQ_W  = 2 * CFG_W;
  localparam int unsigned SUM_W = SQ_W + 2;

  // Stage valids: diff, fold, magnitude, square, compare
  logic [4:0]            vld_q;
  fold_t                 diff_q [3];
  fold_t                 fold_q [3];
  logic [CFG_W-1:0]      mag_q  [3];
  logic [2:0]            near_q;
  logic [SQ_W-1:0]       sq_q   [3];
  logic                  near_all_q;
  logic                  hit_q;
  logic [SQ_W-1:0]       lim_sq_q;

  coord_t                qa_c   [3];
  coord_t                eb_c   [3];
  logic [FOLD_W-1:0]     mag_c  [3];
  logic [SUM_W-1:0]      sum_c;

  // Axis views of the two positions
  always_comb begin
    qa_c[0] = query_i.x;
    qa_c[1] = query_i.y;
    qa_c[2] = query_i.z;
    eb_c[0] = entry_i.x;
    eb_c[1] = entry_i.y;
    eb_c[2] = entry_i.z;
    for (int k = 0; k < 3; k++) begin
      mag_c[k] = fold_q[k][FOLD_W-1] ? FOLD_W'(-fold_q[k]) : FOLD_W'(fold_q[k]);
    end
    sum_c = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
  end

  // Stage valids and the hit flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      vld_q <= {vld_q[3:0], req_i.valid & ~req_i.skip};
      hit_q <= vld_q[3] & near_all_q & (sum_c < SUM_W'(lim_sq_q));
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    lim_sq_q <= contact_i * contact_i;
    for (int k = 0; k < 3; k++) begin
      diff_q[k] <= fold_t'(qa_c[k]) - fold_t'(eb_c[k]);
      fold_q[k] <= fold_once(diff_q[k], box_i);
      mag_q[k]  <= mag_c[k][CFG_W-1:0];
      near_q[k] <= mag_c[k] < FOLD_W'(contact_i);
      sq_q[k]   <= mag_q[k] * mag_q[k];
    end
    near_all_q <= &near_q;
  end

  assign sts_o.busy = |vld_q;
  assign sts_o.hit  = hit_q;

endmodule

// ===== rtl/core/periodic_sphere_overlap_check_core.sv =====
// Write beat: the folded position is stored, then the result loaded. Check beat: the query
// entry is read, min(sphere_count, MAX_SPHERES) entries are swept and the pair pipe drains;
// the single read port of the position memory sweeps one entry per cycle. Either beat first
// reduces an index at or above MAX_SPHERES. One beat is in work at a time; the next is taken
// the cycle after its result is loaded; a result not yet taken holds back the next one.
// Reset clears control state and sets box 65536, contact 4096, count 0; memory not cleared.
module periodic_sphere_overlap_check_core
  import psoc_pkg::*;
#(
  parameter int unsigned MAX_SPHERES = MAX_SPHERES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // Request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 req_type_i,
  input  logic [IDX_W-1:0]     sphere_index_i,
  input  coord_t               pos_x_i,
  input  coord_t               pos_y_i,
  input  coord_t               pos_z_i,
  // Result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 overlap_o,
  output coord_t               stored_x_o,
  output coord_t               stored_y_o,
  output coord_t               stored_z_o
);

  localparam int unsigned ADDR_W   = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int unsigned CNT_W    = ADDR_W + 1;
  localparam int unsigned CMP_W    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int unsigned RECIP_SH = 2 * IDX_W;
  localparam int unsigned PROD_W   = IDX_W + RECIP_SH;
  // Rounded-up reciprocal of the table size; exact quotient for every index when the
  // table is smaller than the index range
  localparam logic [RECIP_SH-1:0] RECIP =
    RECIP_SH'(((64'd1 << RECIP_SH) + 64'(MAX_SPHERES) - 64'd1) / 64'(MAX_SPHERES));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_WRITE,
    ST_QRD,
    ST_QLAT,
    ST_SWEEP,
    ST_DRAIN,
    ST_RESP
  } state_e;

  state_e             state_q;
  logic               req_q;
  logic [IDX_W-1:0]   red_q;
  logic               step_q;
  logic [IDX_W-1:0]   quo_q;
  pos_t               in_pos_q;
  pos_t               q_pos_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               issue_q;
  logic               issue_skip_q;
  logic               hit_acc_q;
  logic               out_valid_q;
  logic               out_hit_q;
  pos_t               out_pos_q;
  logic [CFG_W-1:0]   box_q;
  logic [CFG_W-1:0]   contact_q;
  logic [COUNT_W-1:0] count_q;

  pos_t               pos_mem_q [MAX_SPHERES];
  pos_t               rd_data_q;

  logic [ADDR_W-1:0]  idx_c;
  logic [ADDR_W-1:0]  rd_addr_c;
  logic               wr_en_c;
  pos_t               wr_pos_c;
  fold_t              fx_c, fy_c, fz_c;
  logic [CMP_W-1:0]   n_ext_c;
  logic [CNT_W-1:0]   n_sat_c;
  logic [PROD_W-1:0]  prod_c;
  logic [IDX_W-1:0]   rem_c;
  logic               in_accept_c;
  pair_req_t          pair_req_c;
  pair_sts_t          pair_sts_c;

  assign idx_c       = ADDR_W'(red_q);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept_c = in_valid_i & in_ready_o;
  assign wr_en_c     = (state_q == ST_WRITE);
  assign rd_addr_c   = (state_q == ST_QRD) ? idx_c : cnt_q[ADDR_W-1:0];
  assign prod_c      = PROD_W'(red_q) * PROD_W'(RECIP);
  assign rem_c       = red_q - quo_q * IDX_W'(MAX_SPHERES);

  // Count in use, saturated to the table size
  always_comb begin
    n_ext_c = CMP_W'(count_q);
    if (n_ext_c > CMP_W'(MAX_SPHERES)) begin
      n_sat_c = CNT_W'(MAX_SPHERES);
    end else begin
      n_sat_c = CNT_W'(n_ext_c);
    end
  end

  // Wrapped position for a write beat
  always_comb begin
    fx_c = fold_once(fold_t'(in_pos_q.x), box_q);
    fy_c = fold_once(fold_t'(in_pos_q.y), box_q);
    fz_c = fold_once(fold_t'(in_pos_q.z), box_q);
    wr_pos_c.x = fx_c[COORD_W-1:0];
    wr_pos_c.y = fy_c[COORD_W-1:0];
    wr_pos_c.z = fz_c[COORD_W-1:0];
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q     <= BOX_RST;
      contact_q <= CONTACT_RST;
      count_q   <= COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BOX:     box_q     <= cfg_wdata_i;
        CFG_CONTACT: contact_q <= cfg_wdata_i;
        CFG_COUNT:   count_q   <= cfg_wdata_i[COUNT_W-1:0];
        default:     ;
      endcase
    end
  end

  // Position memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_c) begin
      pos_mem_q[idx_c] <= wr_pos_c;
    end
    rd_data_q <= pos_mem_q[rd_addr_c];
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      req_q        <= REQ_WRITE;
      red_q        <= '0;
      step_q       <= 1'b0;
      quo_q        <= '0;
      in_pos_q     <= '0;
      q_pos_q      <= '0;
      cnt_q        <= '0;
      issue_q      <= 1'b0;
      issue_skip_q <= 1'b0;
      hit_acc_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_hit_q    <= 1'b0;
      out_pos_q    <= '0;
    end else begin
      issue_q <= 1'b0;
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pair_sts_c.hit) begin
        hit_acc_q <= 1'b1;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_accept_c) begin
            req_q      <= req_type_i;
            red_q      <= sphere_index_i;
            step_q     <= 1'b0;
            in_pos_q.x <= pos_x_i;
            in_pos_q.y <= pos_y_i;
            in_pos_q.z <= pos_z_i;
            hit_acc_q  <= 1'b0;
            if (CMP_W'(sphere_index_i) >= CMP_W'(MAX_SPHERES)) begin
              state_q <= ST_REDUCE;
            end else if (req_type_i == REQ_CHECK) begin
              state_q <= ST_QRD;
            end else begin
              state_q <= ST_WRITE;
            end
          end
        end
        // Index modulo table size by reciprocal multiply: quotient, then remainder
        ST_REDUCE: begin
          if (!step_q) begin
            quo_q  <= prod_c[PROD_W-1:RECIP_SH];
            step_q <= 1'b1;
          end else begin
            red_q   <= rem_c;
            state_q <= (req_q == REQ_CHECK) ? ST_QRD : ST_WRITE;
          end
        end
        ST_WRITE: begin
          q_pos_q <= wr_pos_c;
          state_q <= ST_RESP;
        end
        ST_QRD: begin
          state_q <= ST_QLAT;
        end
        ST_QLAT: begin
          q_pos_q <= rd_data_q;
          cnt_q   <= '0;
          state_q <= (n_sat_c == '0) ? ST_RESP : ST_SWEEP;
        end
        // One entry read per cycle, fed to the pair pipe from the registered read data
        ST_SWEEP: begin
          issue_q      <= 1'b1;
          issue_skip_q <= (cnt_q[ADDR_W-1:0] == idx_c);
          cnt_q        <= cnt_q + 1'b1;
          if (cnt_q == n_sat_c - 1'b1) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!issue_q && !pair_sts_c.busy) begin
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= hit_acc_q;
            out_pos_q   <= q_pos_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign pair_req_c.valid = issue_q;
  assign pair_req_c.skip  = issue_skip_q;

  psoc_pair_pipe u_pair_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .box_i     (box_q),
    .contact_i (contact_q),
    .req_i     (pair_req_c),
    .entry_i   (rd_data_q),
    .query_i   (q_pos_q),
    .sts_o     (pair_sts_c)
  );

  assign out_valid_o = out_valid_q;
  assign overlap_o   = out_hit_q;
  assign stored_x_o  = out_pos_q.x;
  assign stored_y_o  = out_pos_q.y;
  assign stored_z_o  = out_pos_q.z;

  // Checks
  a_sweep_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> (cnt_q < n_sat_c))
    else $error("sweep counter past the count in use");

  a_pipe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!pair_sts_c.busy && !issue_q))
    else $error("pair pipe busy while idle");

  a_write_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> !hit_acc_q)
    else $error("write beat carries an overlap");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESP))
    else $error("result loaded outside the response state");

endmodule

// ===== tb/psoc_overlap_checker.sv =====
`timescale 1ns / 1ps

// Watches the config port and both channels, keeps a mirror of the
// position table and registers, and compares every result beat in order.
module psoc_overlap_checker
  import psoc_pkg::*;
#(
  parameter int unsigned MAX_SPHERES = MAX_SPHERES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 req_type_i,
  input  logic [IDX_W-1:0]     sphere_index_i,
  input  coord_t               pos_x_i,
  input  coord_t               pos_y_i,
  input  coord_t               pos_z_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 overlap_i,
  input  coord_t               stored_x_i,
  input  coord_t               stored_y_i,
  input  coord_t               stored_z_i,
  output int unsigned          pending_o,
  output int unsigned          errors_o
);

  typedef struct {
    logic   overlap;
    coord_t x;
    coord_t y;
    coord_t z;
  } sphere_report_t;

  // Predicted result beats, oldest first
  sphere_report_t sphere_reports_q[$];

  // Mirror of the position table and the registers
  coord_t           mirror_x [MAX_SPHERES];
  coord_t           mirror_y [MAX_SPHERES];
  coord_t           mirror_z [MAX_SPHERES];
  logic [CFG_W-1:0]   box_len;
  logic [CFG_W-1:0]   contact_len;
  logic [COUNT_W-1:0] active_count;

  int unsigned mismatches = 0;
  int unsigned result_no  = 0;

  assign errors_o = mismatches;

  task automatic flag_mismatch(string msg);
    $display("%0t ns: result %0d: %s", $time, result_no, msg);
    mismatches++;
  endtask

  // One fold into the box; half-box bounds tested as 2*c against the box
  function automatic longint fold_box(longint c);
    longint b;
    b = longint'(box_len);
    if (2 * c > b) begin
      return c - b;
    end
    if (2 * c < -b) begin
      return c + b;
    end
    return c;
  endfunction

  // Folded coordinate as stored: wrapped back to the coordinate width
  function automatic coord_t fold_to_cell(coord_t raw);
    longint f;
    f = fold_box(longint'(raw));
    return f[COORD_W-1:0];
  endfunction

  // Strict contact test on minimum-image differences, no square root
  function automatic bit spheres_touch(int unsigned a, int unsigned b);
    longint d[3];
    longint m;
    longint sum;
    longint lim;
    lim = longint'(contact_len);
    sum = 0;
    d[0] = fold_box(longint'(mirror_x[a]) - longint'(mirror_x[b]));
    d[1] = fold_box(longint'(mirror_y[a]) - longint'(mirror_y[b]));
    d[2] = fold_box(longint'(mirror_z[a]) - longint'(mirror_z[b]));
    for (int k = 0; k < 3; k++) begin
      m = (d[k] < 0) ? -d[k] : d[k];
      // far on one axis: no overlap whatever the others are
      if (m >= lim) begin
        return 1'b0;
      end
      sum += m * m;
    end
    return sum < lim * lim;
  endfunction

  // Applies one request beat to the mirror and returns the result it yields
  function automatic sphere_report_t compute_report(logic kind, logic [IDX_W-1:0] idx_raw,
                                                    coord_t px, coord_t py, coord_t pz);
    sphere_report_t r;
    int unsigned    idx;
    int unsigned    n;
    idx = int'(idx_raw) % MAX_SPHERES;
    r.overlap = 1'b0;
    if (kind == REQ_WRITE) begin
      mirror_x[idx] = fold_to_cell(px);
      mirror_y[idx] = fold_to_cell(py);
      mirror_z[idx] = fold_to_cell(pz);
    end else begin
      // count saturates at the table size
      n = active_count;
      if (n > MAX_SPHERES) begin
        n = MAX_SPHERES;
      end
      for (int unsigned i = 0; i < n; i++) begin
        if (i != idx && spheres_touch(idx, i)) begin
          r.overlap = 1'b1;
          break;
        end
      end
    end
    r.x = mirror_x[idx];
    r.y = mirror_y[idx];
    r.z = mirror_z[idx];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sphere_report_t want;
    if (!rst_ni) begin
      box_len      = BOX_RST;
      contact_len  = CONTACT_RST;
      active_count = COUNT_RST;
      sphere_reports_q.delete();
      pending_o <= 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BOX:     box_len = cfg_wdata_i;
          CFG_CONTACT: contact_len = cfg_wdata_i;
          CFG_COUNT:   active_count = cfg_wdata_i[COUNT_W-1:0];
          default: ;
        endcase
      end

      // result beat against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (sphere_reports_q.size() == 0) begin
          flag_mismatch("result beat with no request outstanding");
        end else begin
          want = sphere_reports_q.pop_front();
          if (overlap_i !== want.overlap || stored_x_i !== want.x ||
              stored_y_i !== want.y || stored_z_i !== want.z) begin
            flag_mismatch($sformatf(
              "got ovl %0b xyz %0d %0d %0d, want ovl %0b xyz %0d %0d %0d",
              overlap_i, stored_x_i, stored_y_i, stored_z_i,
              want.overlap, want.x, want.y, want.z));
          end
        end
        result_no++;
      end

      // request beat
      if (in_valid_i && in_ready_i) begin
        sphere_reports_q.push_back(compute_report(req_type_i, sphere_index_i,
                                                  pos_x_i, pos_y_i, pos_z_i));
      end

      pending_o <= sphere_reports_q.size();
    end
  end

endmodule

// ===== tb/tb_periodic_sphere_overlap_check_core.sv =====
`timescale 1ns / 1ps

module tb_periodic_sphere_overlap_check_core;
  import psoc_pkg::*;

  localparam int unsigned SPHERES      = MAX_SPHERES_DEF;
  localparam int unsigned RANDOM_ITEMS = 535;
  localparam int unsigned STALL_LIMIT  = 20000;
  // margin on top of the longest write beat
  localparam int unsigned DRAIN_CYCLES = 16;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic                 req_type;
  logic [IDX_W-1:0]     sphere_index;
  coord_t               pos_x;
  coord_t               pos_y;
  coord_t               pos_z;
  logic                 out_valid;
  logic                 out_ready;
  logic                 overlap;
  coord_t               stored_x;
  coord_t               stored_y;
  coord_t               stored_z;

  int unsigned pending_beats;
  int unsigned mismatch_total;
  int unsigned idle_cycles = 0;

  // Stimulus-side bookkeeping
  logic [SPHERES-1:0] filled = '0;
  int unsigned        filled_list[$];
  logic [CFG_W-1:0]   cur_box;
  logic [CFG_W-1:0]   cur_contact;
  int unsigned        items_sent = 0;
  int unsigned        cluster_span;
  coord_t             hub_x;
  coord_t             hub_y;
  coord_t             hub_z;
  bit                 valid_held = 1'b0;
  bit                 no_gaps = 1'b0;

  periodic_sphere_overlap_check_core DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .req_type_i     (req_type),
    .sphere_index_i (sphere_index),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .pos_z_i        (pos_z),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .overlap_o      (overlap),
    .stored_x_o     (stored_x),
    .stored_y_o     (stored_y),
    .stored_z_o     (stored_z)
  );

  psoc_overlap_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .req_type_i     (req_type),
    .sphere_index_i (sphere_index),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .pos_z_i        (pos_z),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .overlap_i      (overlap),
    .stored_x_i     (stored_x),
    .stored_y_i     (stored_y),
    .stored_z_i     (stored_z),
    .pending_o      (pending_beats),
    .errors_o       (mismatch_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result-side back-pressure: short stalls, a few long ones, open stretches
  initial begin
    int unsigned len;
    out_ready <= 1'b0;
    forever begin
      case ($urandom_range(0, 9))
        0: begin
          out_ready <= 1'b1;
          len = $urandom_range(30, 200);
        end
        1: begin
          out_ready <= 1'b0;
          len = $urandom_range(15, 60);
        end
        2, 3, 4: begin
          out_ready <= 1'b0;
          len = $urandom_range(1, 3);
        end
        default: begin
          out_ready <= 1'b1;
          len = $urandom_range(1, 8);
        end
      endcase
      repeat (len) @(posedge clk);
    end
  end

  // Watchdog: cycles without any accepted beat or register write
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Random gap before a request beat; valid drops only when a gap is taken
  task automatic hold_gap();
    int unsigned gap;
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(0, 19))
        0:             gap = $urandom_range(10, 40);
        1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
        default:       gap = 0;
      endcase
    end
    if (gap > 0) begin
      if (valid_held) begin
        in_valid <= 1'b0;
        valid_held = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
  endtask

  // Send one request beat and return at the edge that accepts it
  task automatic issue(logic kind, int unsigned idx, coord_t x, coord_t y, coord_t z);
    hold_gap();
    in_valid     <= 1'b1;
    req_type     <= kind;
    sphere_index <= idx[IDX_W-1:0];
    pos_x        <= x;
    pos_y        <= y;
    pos_z        <= z;
    valid_held = 1'b1;
    if (kind == REQ_WRITE && !filled[idx]) begin
      filled[idx] = 1'b1;
      filled_list.push_back(idx);
    end
    items_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic check_sphere(int unsigned idx);
    issue(REQ_CHECK, idx, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
  endtask

  // Drop valid and wait until the block has nothing left in flight
  task automatic settle();
    if (valid_held) begin
      in_valid <= 1'b0;
      valid_held = 1'b0;
    end
    // let the checker count the beat accepted at this edge
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [CFG_W-1:0] box, logic [CFG_W-1:0] contact,
                              logic [COUNT_W-1:0] count);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_BOX;
    cfg_wdata <= box;
    @(posedge clk);
    cfg_idx   <= CFG_CONTACT;
    cfg_wdata <= contact;
    @(posedge clk);
    cfg_idx   <= CFG_COUNT;
    cfg_wdata <= CFG_W'(count);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_box     = box;
    cur_contact = contact;
  endtask

  // Coordinate near a cluster hub, with some noise, box shifts and wall hits
  function automatic coord_t cluster_coord(coord_t hub);
    longint off;
    longint c;
    off = longint'($urandom_range(0, 2 * cluster_span)) - longint'(cluster_span);
    c = longint'(hub) + off;
    case ($urandom_range(0, 11))
      0: c = $urandom;
      1: c = c + longint'(cur_box);
      2: c = c - longint'(cur_box);
      3: c = longint'(cur_box / 2) + off;
      4: c = -longint'(cur_box / 2) + off;
      default: ;
    endcase
    return c[COORD_W-1:0];
  endfunction

  task automatic pick_cluster(bit wide_hub);
    if (cur_contact == 0) begin
      cluster_span = $urandom_range(1, 65536);
    end else begin
      cluster_span = int'((longint'(cur_contact) * $urandom_range(1, 6)) / 2 + 1);
    end
    hub_x = wide_hub ? coord_t'($urandom) : '0;
    hub_y = wide_hub ? coord_t'($urandom) : '0;
    hub_z = wide_hub ? coord_t'($urandom) : '0;
  endtask

  // One setting of the registers, spheres in use filled, then mixed traffic
  task automatic random_phase();
    logic [CFG_W-1:0]   box;
    logic [CFG_W-1:0]   contact;
    logic [COUNT_W-1:0] count;
    int unsigned        n;
    int unsigned        pick;
    int unsigned        idx;
    case ($urandom_range(0, 7))
      0:       contact = '0;
      1:       contact = {CFG_W{1'b1}};
      2:       contact = CFG_W'($urandom);
      default: contact = CFG_W'($urandom_range(256, 16384));
    endcase
    case ($urandom_range(0, 5))
      0:       box = CFG_W'(1);
      1:       box = {CFG_W{1'b1}};
      2:       box = BOX_RST;
      3:       box = CFG_W'($urandom_range(2, 1 << 20));
      4:       box = CFG_W'($urandom) | CFG_W'(1);
      default: box = CFG_W'(longint'(contact) * $urandom_range(2, 8));
    endcase
    if (box == 0) begin
      box = BOX_RST;
    end
    case ($urandom_range(0, 9))
      0:       count = '0;
      1:       count = COUNT_W'(1);
      2:       count = COUNT_W'($urandom_range(25, 64));
      default: count = COUNT_W'($urandom_range(2, 24));
    endcase
    n = count;
    write_config(box, contact, count);
    pick_cluster($urandom_range(0, 3) == 0);
    no_gaps = ($urandom_range(0, 4) == 0);

    // every sphere in use gets a position first
    for (idx = 0; idx < n; idx++) begin
      issue(REQ_WRITE, idx, cluster_coord(hub_x), cluster_coord(hub_y), cluster_coord(hub_z));
    end

    repeat ($urandom_range(15, 45)) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if (n > 0 && $urandom_range(0, 99) < 85) begin
          check_sphere($urandom_range(0, n - 1));
        end else begin
          check_sphere(filled_list[$urandom_range(0, filled_list.size() - 1)]);
        end
      end else if (pick < 88 && n > 0) begin
        issue(REQ_WRITE, $urandom_range(0, n - 1),
              cluster_coord(hub_x), cluster_coord(hub_y), cluster_coord(hub_z));
      end else begin
        issue(REQ_WRITE, $urandom_range(0, SPHERES - 1),
              coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned random_base;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= CFG_BOX;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    req_type     <= REQ_WRITE;
    sphere_index <= '0;
    pos_x        <= '0;
    pos_y        <= '0;
    pos_z        <= '0;
    cur_box     = BOX_RST;
    cur_contact = CONTACT_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // folds at and past the half-box bounds, both table ends, count zero
    issue(REQ_WRITE, 0, 8388607, -8388608, 32768);
    issue(REQ_WRITE, SPHERES - 1, 32769, -32768, -32769);
    check_sphere(0);

    write_config(BOX_RST, CONTACT_RST, COUNT_W'(2));
    // one axis just inside contact, then exactly at it
    issue(REQ_WRITE, 1, 0, 0, 0);
    issue(REQ_WRITE, 0, 4095, 0, 0);
    check_sphere(0);
    issue(REQ_WRITE, 0, 4096, 0, 0);
    check_sphere(1);
    // diagonal just inside contact
    issue(REQ_WRITE, 0, 2896, 2896, 0);
    check_sphere(0);
    // pair touching only through the box wall
    issue(REQ_WRITE, 0, 32767, 0, 0);
    issue(REQ_WRITE, 1, -32767, 0, 0);
    check_sphere(1);

    write_config(BOX_RST, CFG_W'(5120), COUNT_W'(2));
    // squared distance equal to the contact square, then just below
    issue(REQ_WRITE, 0, 3072, 4096, 0);
    issue(REQ_WRITE, 1, 0, 0, 0);
    check_sphere(0);
    issue(REQ_WRITE, 0, 3072, 4095, 0);
    check_sphere(0);

    // zero box leaves values alone, zero contact never overlaps
    write_config('0, '0, COUNT_W'(2));
    issue(REQ_WRITE, 0, 8388607, -8388608, 8388607);
    issue(REQ_WRITE, 1, 8388607, -8388608, 8388607);
    check_sphere(1);

    // largest box and contact
    write_config({CFG_W{1'b1}}, {CFG_W{1'b1}}, COUNT_W'(2));
    check_sphere(0);

    random_base = items_sent;
    while (items_sent - random_base < RANDOM_ITEMS) begin
      random_phase();
    end

    settle();
    repeat (40) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
